/* src/gclu_pkg.sv */
`default_nettype none

package gclu_pkg;

   // Payload widths of the channels
   localparam int unsigned OPERAND_BITS = 32;
   localparam int unsigned LCM_BITS     = 64;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_FIN,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   // Operation of the shared adder
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

`default_nettype wire

/* src/gclu_if.sv */
`default_nettype none

interface gclu_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [gclu_pkg::OPERAND_BITS-1:0]     first_value;
   logic [gclu_pkg::OPERAND_BITS-1:0]     second_value;

   modport source (output valid, output first_value, output second_value, input ready);
   modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface gclu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [gclu_pkg::OPERAND_BITS-1:0]     gcd_result;
   logic [gclu_pkg::LCM_BITS-1:0]         lcm_result;

   modport source (output valid, output gcd_result, output lcm_result, input ready);
   modport sink   (input valid, input gcd_result, input lcm_result, output ready);
endinterface

`default_nettype wire

/* src/gclu_alu.sv */
`default_nettype none

// Shared adder/subtractor. For a subtract, carry_out high means op_a >= op_b.
module gclu_alu #(
   parameter int unsigned WIDTH = 32
) (
   input  wire gclu_pkg::alu_op_type op,
   input  wire logic [WIDTH-1:0]     op_a,
   input  wire logic [WIDTH-1:0]     op_b,
   output logic [WIDTH-1:0]          sum,
   output logic                      carry_out
);

   logic [WIDTH-1:0] b_eff;
   logic             cin;

   always_comb begin
      case (op)
         gclu_pkg::ALU_SUB: begin
            b_eff = ~op_b;
            cin   = 1'b1;
         end
         default: begin
            b_eff = op_b;
            cin   = 1'b0;
         end
      endcase
   end

   assign {carry_out, sum} = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

endmodule

`default_nettype wire

/* src/gcd_lcm_unit.sv */
`default_nettype none

// GCD / LCM unit. Each request word carries two unsigned operands (low WIDTH bits used);
// one response word returns gcd_result and the double-width lcm_result = (first/gcd)*second.
// gcd(a,0) = a, and lcm_result is 0 whenever either operand is 0. The unit handles one word
// at a time and all work runs through a single WIDTH-bit adder/subtractor: a binary
// GCD loop (one shift, subtract or swap per cycle), a step to restore the common power
// of two, a restoring divide and a shift-add multiply. A word with a zero operand skips
// straight to the response; req ready stays low from accept until the response word is
// taken.
module gcd_lcm_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gclu_req_if.sink    req_chan,
   gclu_rsp_if.source  rsp_chan
);

   localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

   gclu_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   gclu_pkg::alu_op_type alu_op;
   logic [WIDTH-1:0]     alu_a, alu_b, alu_sum;
   logic                 alu_cout;

   logic [WIDTH-1:0] req_x, req_y;
   logic [WIDTH-1:0] partial;
   logic [WIDTH:0]   mul_next;
   logic             accept_req, accept_rsp, zero_op, gcd_end, div_take;

   assign req_x      = req_chan.first_value[WIDTH-1:0];
   assign req_y      = req_chan.second_value[WIDTH-1:0];
   assign accept_req = req_chan.valid && req_chan.ready;
   assign accept_rsp = rsp_chan.valid && rsp_chan.ready;
   assign zero_op    = (req_x == '0) || (req_y == '0);
   assign gcd_end    = (a_ff == '0) || (b_ff == '0);

   // divide step: shift next dividend bit into the remainder
   assign partial  = {r_ff[WIDTH-2:0], q_ff[WIDTH-1]};
   assign div_take = r_ff[WIDTH-1] || alu_cout;
   assign mul_next = q_ff[0] ? {alu_cout, alu_sum} : {1'b0, hi_ff};

   gclu_alu #(.WIDTH(WIDTH)) u_alu (
      .op        (alu_op),
      .op_a      (alu_a),
      .op_b      (alu_b),
      .sum       (alu_sum),
      .carry_out (alu_cout)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gclu_pkg::ST_IDLE: begin
            if (accept_req) begin
               state_in = zero_op ? gclu_pkg::ST_DONE : gclu_pkg::ST_GCD;
            end
         end
         gclu_pkg::ST_GCD: begin
            if (gcd_end) begin
               state_in = gclu_pkg::ST_FIN;
            end
         end
         gclu_pkg::ST_FIN: state_in = gclu_pkg::ST_DIV;
         gclu_pkg::ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = gclu_pkg::ST_MUL;
            end
         end
         gclu_pkg::ST_MUL: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = gclu_pkg::ST_DONE;
            end
         end
         gclu_pkg::ST_DONE: begin
            if (accept_rsp) begin
               state_in = gclu_pkg::ST_IDLE;
            end
         end
         default: state_in = gclu_pkg::ST_IDLE;
      endcase
   end

   // outputs and adder control
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      alu_op         = gclu_pkg::ALU_SUB;
      alu_a          = a_ff;
      alu_b          = b_ff;
      case (state_ff)
         gclu_pkg::ST_IDLE: req_chan.ready = 1'b1;
         gclu_pkg::ST_DIV: begin
            alu_a = partial;
            alu_b = g_ff;
         end
         gclu_pkg::ST_MUL: begin
            alu_op = gclu_pkg::ALU_ADD;
            alu_a  = hi_ff;
            alu_b  = y_ff;
         end
         gclu_pkg::ST_DONE: rsp_chan.valid = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      r_in   = r_ff;
      q_in   = q_ff;
      hi_in  = hi_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         gclu_pkg::ST_IDLE: begin
            x_in  = req_x;
            y_in  = req_y;
            a_in  = req_x;
            b_in  = req_y;
            k_in  = '0;
            // zero operand: result is ready at once
            g_in  = req_x | req_y;
            hi_in = '0;
            q_in  = '0;
         end
         gclu_pkg::ST_GCD: begin
            if (!gcd_end) begin
               if (!a_ff[0] && !b_ff[0]) begin
                  a_in = a_ff >> 1;
                  b_in = b_ff >> 1;
                  k_in = k_ff + 1'b1;
               end else if (!a_ff[0]) begin
                  a_in = a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_in = b_ff >> 1;
               end else if (alu_cout) begin
                  a_in = alu_sum;
               end else begin
                  // a < b: swap so the next subtract runs the right way
                  a_in = b_ff;
                  b_in = a_ff;
               end
            end
         end
         gclu_pkg::ST_FIN: begin
            g_in   = (a_ff | b_ff) << k_ff;
            r_in   = '0;
            q_in   = x_ff;
            cnt_in = '0;
         end
         gclu_pkg::ST_DIV: begin
            r_in   = div_take ? alu_sum : partial;
            q_in   = {q_ff[WIDTH-2:0], div_take};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               hi_in  = '0;
               cnt_in = '0;
            end
         end
         gclu_pkg::ST_MUL: begin
            hi_in  = mul_next[WIDTH:1];
            q_in   = {mul_next[0], q_ff[WIDTH-1:1]};
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gclu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      hi_ff  <= hi_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_chan.gcd_result = gclu_pkg::OPERAND_BITS'(g_ff);
   assign rsp_chan.lcm_result = gclu_pkg::LCM_BITS'({hi_ff, q_ff});

endmodule

`default_nettype wire

/* src/gclu_checker.sv */
`default_nettype none

module gclu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] gcd_result,
   input wire logic [63:0] lcm_result
);

   // a pending response word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before it was taken");

   // one word in flight: no new request while a response is offered
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("unit ready again right after accepting a word");

   a_lcm_needs_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (lcm_result != 64'd0) |-> (gcd_result != 32'd0))
      else $error("nonzero lcm with zero gcd");

endmodule

bind gcd_lcm_unit gclu_checker u_gclu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .gcd_result (rsp_chan.gcd_result),
   .lcm_result (rsp_chan.lcm_result)
);

`default_nettype wire
